[hdl/mrpe_pkg.sv]
// shared types, constants and microcode program of the market record encoder
`timescale 1ns / 1ps
`default_nettype none

package mrpe_pkg;

  typedef struct packed {
    logic        is_quote;
    logic [63:0] sequence_req;
    logic [31:0] date;
    logic [31:0] day_ms;
    logic [63:0] price_or_bid_bits;
    logic [63:0] ask_bits;
    logic [31:0] size_or_bid_size;
    logic [31:0] ask_qty;
    logic [31:0] cond_or_bid_cond;
    logic [31:0] ask_cond;
    logic [31:0] exch_or_bid_exch;
    logic [31:0] ask_exch;
  } rec_in_t;

  typedef struct packed {
    logic [15:0] out_bytes;
    logic [1:0]  byte_count;
    logic        last;
  } rec_out_t;

  typedef enum logic [1:0] {
    OP_BRQ,
    OP_INT,
    OP_DBL
  } op_e;

  typedef enum logic [3:0] {
    SRC_SEQ,
    SRC_DATE,
    SRC_MS,
    SRC_BID,
    SRC_ASK,
    SRC_BSIZE,
    SRC_ASIZE,
    SRC_BCOND,
    SRC_ACOND,
    SRC_BEXCH,
    SRC_AEXCH
  } src_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_e;

  typedef logic [4:0] pc_t;

  localparam pc_t QUOTE_PC = 5'd8;

  // one microcode step
  typedef struct packed {
    op_e        op;
    src_e       src;
    logic [7:0] tag;
    logic       last_step;
  } ucode_t;

  typedef struct packed {
    logic       start;
    logic       step_en;
    logic       flush_en;
    ucode_t     uw;
  } seq_ctrl_t;

  typedef struct packed {
    logic field_done;
    logic need_flush;
    logic is_quote;
  } dp_stat_t;

  localparam logic WT_VARINT = 1'b0;
  localparam logic WT_FIXED64 = 1'b1;

  function automatic logic [7:0] mk_tag(input logic [3:0] fnum, input logic wt);
    mk_tag = {1'b0, fnum, 2'b00, wt};
  endfunction

  // program: branch, trade fields, then quote fields
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    w = '{op: OP_INT, src: SRC_DATE, tag: 8'h00, last_step: 1'b1};
    case (pc)
      5'd0:  w = '{OP_BRQ, SRC_SEQ,   8'h00,                       1'b0};
      5'd1:  w = '{OP_INT, SRC_SEQ,   mk_tag(4'd1, WT_VARINT),     1'b0};
      5'd2:  w = '{OP_INT, SRC_DATE,  mk_tag(4'd2, WT_VARINT),     1'b0};
      5'd3:  w = '{OP_INT, SRC_MS,    mk_tag(4'd3, WT_VARINT),     1'b0};
      5'd4:  w = '{OP_DBL, SRC_BID,   mk_tag(4'd4, WT_FIXED64),    1'b0};
      5'd5:  w = '{OP_INT, SRC_BSIZE, mk_tag(4'd5, WT_VARINT),     1'b0};
      5'd6:  w = '{OP_INT, SRC_BCOND, mk_tag(4'd6, WT_VARINT),     1'b0};
      5'd7:  w = '{OP_INT, SRC_BEXCH, mk_tag(4'd7, WT_VARINT),     1'b1};
      5'd8:  w = '{OP_INT, SRC_DATE,  mk_tag(4'd1, WT_VARINT),     1'b0};
      5'd9:  w = '{OP_INT, SRC_MS,    mk_tag(4'd2, WT_VARINT),     1'b0};
      5'd10: w = '{OP_DBL, SRC_BID,   mk_tag(4'd3, WT_FIXED64),    1'b0};
      5'd11: w = '{OP_DBL, SRC_ASK,   mk_tag(4'd4, WT_FIXED64),    1'b0};
      5'd12: w = '{OP_INT, SRC_BSIZE, mk_tag(4'd5, WT_VARINT),     1'b0};
      5'd13: w = '{OP_INT, SRC_ASIZE, mk_tag(4'd6, WT_VARINT),     1'b0};
      5'd14: w = '{OP_INT, SRC_BCOND, mk_tag(4'd7, WT_VARINT),     1'b0};
      5'd15: w = '{OP_INT, SRC_ACOND, mk_tag(4'd8, WT_VARINT),     1'b0};
      5'd16: w = '{OP_INT, SRC_BEXCH, mk_tag(4'd9, WT_VARINT),     1'b0};
      5'd17: w = '{OP_INT, SRC_AEXCH, mk_tag(4'd10, WT_VARINT),    1'b1};
      default: w = '{OP_INT, SRC_DATE, 8'h00, 1'b1};
    endcase
    ucode_rom = w;
  endfunction

endpackage

`default_nettype wire

[hdl/mrpe_seq.sv]
// microcode sequencer: step counter, program rom and record control
`timescale 1ns / 1ps
`default_nettype none

module mrpe_seq
  import mrpe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      out_free_i,
  input  wire dp_stat_t  stat_i,
  output seq_ctrl_t      ctrl_o,
  output logic           busy_o
);

  state_e state_q, state_d;
  pc_t    pc_q, pc_d;
  ucode_t uw;

  assign uw = ucode_rom(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    pc_d             = pc_q;
    ctrl_o.start     = 1'b0;
    ctrl_o.step_en   = 1'b0;
    ctrl_o.flush_en  = 1'b0;
    ctrl_o.uw        = uw;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          pc_d         = '0;
          state_d      = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free_i) begin
          ctrl_o.step_en = 1'b1;
          if (uw.op == OP_BRQ) begin
            pc_d = stat_i.is_quote ? QUOTE_PC : pc_q + 5'd1;
          end else if (stat_i.field_done) begin
            pc_d = pc_q + 5'd1;
            if (uw.last_step) begin
              state_d = stat_i.need_flush ? ST_FLUSH : ST_IDLE;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_free_i) begin
          ctrl_o.flush_en = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[hdl/mrpe_dp.sv]
// datapath: record register, field select, varint and fixed64 byte generation, word packing
`timescale 1ns / 1ps
`default_nettype none

module mrpe_dp
  import mrpe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire rec_in_t   in_data_i,
  input  wire seq_ctrl_t ctrl_i,
  output dp_stat_t       stat_o,
  output logic           emit_o,
  output rec_out_t       word_o
);

  rec_in_t     rec_q;
  logic [63:0] rem_q, rem_d;
  logic [2:0]  dcnt_q, dcnt_d;
  logic        cont_q, cont_d;
  logic [15:0] hb_q, hb_d;
  logic [1:0]  hcnt_q, hcnt_d;

  logic [63:0] fval;
  logic [15:0] nb;
  logic [1:0]  nn;
  logic        done;
  logic [31:0] pack;
  logic [2:0]  total;
  logic        end_now;

  always_comb begin
    case (ctrl_i.uw.src)
      SRC_SEQ:   fval = rec_q.sequence_req;
      SRC_DATE:  fval = {32'd0, rec_q.date};
      SRC_MS:    fval = {32'd0, rec_q.day_ms};
      SRC_BID:   fval = rec_q.price_or_bid_bits;
      SRC_ASK:   fval = rec_q.ask_bits;
      SRC_BSIZE: fval = {32'd0, rec_q.size_or_bid_size};
      SRC_ASIZE: fval = {32'd0, rec_q.ask_qty};
      SRC_BCOND: fval = {32'd0, rec_q.cond_or_bid_cond};
      SRC_ACOND: fval = {32'd0, rec_q.ask_cond};
      SRC_BEXCH: fval = {32'd0, rec_q.exch_or_bid_exch};
      SRC_AEXCH: fval = {32'd0, rec_q.ask_exch};
      default:   fval = '0;
    endcase
  end

  // byte generation for the current step
  always_comb begin
    nb     = '0;
    nn     = 2'd0;
    done   = 1'b0;
    rem_d  = rem_q;
    dcnt_d = dcnt_q;
    cont_d = cont_q;
    case (ctrl_i.uw.op)
      OP_INT: begin
        if (!cont_q) begin
          if (fval == 64'd0) begin
            done = 1'b1;
          end else begin
            // tag plus first group
            nb     = {|fval[63:7], fval[6:0], ctrl_i.uw.tag};
            nn     = 2'd2;
            rem_d  = fval >> 7;
            done   = ~|fval[63:7];
            cont_d = |fval[63:7];
          end
        end else begin
          if (|rem_q[63:7]) begin
            nb    = {|rem_q[63:14], rem_q[13:7], 1'b1, rem_q[6:0]};
            nn    = 2'd2;
            rem_d = rem_q >> 14;
            done  = ~|rem_q[63:14];
          end else begin
            nb    = {9'd0, rem_q[6:0]};
            nn    = 2'd1;
            rem_d = '0;
            done  = 1'b1;
          end
          cont_d = ~done;
        end
      end
      OP_DBL: begin
        if (!cont_q) begin
          // both signed zeros are skipped
          if (fval[62:0] == 63'd0) begin
            done = 1'b1;
          end else begin
            nb     = {fval[7:0], ctrl_i.uw.tag};
            nn     = 2'd2;
            rem_d  = fval >> 8;
            dcnt_d = 3'd7;
            cont_d = 1'b1;
          end
        end else begin
          if (dcnt_q >= 3'd2) begin
            nb     = rem_q[15:0];
            nn     = 2'd2;
            dcnt_d = dcnt_q - 3'd2;
          end else begin
            nb     = {8'd0, rem_q[7:0]};
            nn     = 2'd1;
            dcnt_d = 3'd0;
          end
          rem_d  = rem_q >> 16;
          done   = (dcnt_d == 3'd0);
          cont_d = ~done;
        end
      end
      default: begin
        nb = '0;
      end
    endcase
  end

  // pack generated bytes behind the held ones
  assign pack    = {16'd0, hb_q} | ({16'd0, nb} << {hcnt_q, 3'b000});
  assign total   = {1'b0, hcnt_q} + {1'b0, nn};
  assign end_now = done & ctrl_i.uw.last_step;

  always_comb begin
    emit_o = 1'b0;
    word_o = '{out_bytes: pack[15:0], byte_count: 2'd2, last: 1'b0};
    hb_d   = hb_q;
    hcnt_d = hcnt_q;
    if (ctrl_i.start) begin
      hb_d   = '0;
      hcnt_d = 2'd0;
    end else if (ctrl_i.flush_en) begin
      emit_o = 1'b1;
      word_o = '{out_bytes: hb_q, byte_count: hcnt_q, last: 1'b1};
      hb_d   = '0;
      hcnt_d = 2'd0;
    end else if (ctrl_i.step_en) begin
      if (total > 3'd2) begin
        emit_o = 1'b1;
        hb_d   = pack[31:16];
        hcnt_d = 2'(total - 3'd2);
      end else if (end_now) begin
        // whole remainder fits, close the record here
        emit_o = 1'b1;
        word_o = '{out_bytes: pack[15:0], byte_count: total[1:0], last: 1'b1};
        hb_d   = '0;
        hcnt_d = 2'd0;
      end else begin
        hb_d   = pack[15:0];
        hcnt_d = total[1:0];
      end
    end
  end

  assign stat_o.field_done = done;
  assign stat_o.need_flush = end_now & (total > 3'd2);
  assign stat_o.is_quote   = rec_q.is_quote;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rec_q <= in_data_i;
    end
    if (ctrl_i.step_en) begin
      rem_q  <= rem_d;
      dcnt_q <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_q <= 1'b0;
      hb_q   <= '0;
      hcnt_q <= 2'd0;
    end else begin
      if (ctrl_i.start) begin
        cont_q <= 1'b0;
      end else if (ctrl_i.step_en) begin
        cont_q <= cont_d;
      end
      hb_q   <= hb_d;
      hcnt_q <= hcnt_d;
    end
  end

endmodule

`default_nettype wire

[hdl/market_record_protobuf_encoder_core.sv]
// top level of the market record protobuf encoder: sequencer, datapath and output register
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake               word
// in       input      in_valid_i / in_stall_o  rec_in_t, one trade or quote record
// out      output     out_valid_o / out_stall_i rec_out_t, up to two message bytes
//
// one record is loaded, then takes one branch step and one step per two bytes
// of each present field (tag rides with the first value byte)
// a skipped zero field still costs one step; a flush step follows when bytes remain
// reset clears the sequencer, the datapath hold state and the output valid flag; a stall on out holds the step
// in_stall_o drops once the final word of a record sits in the output register

module market_record_protobuf_encoder_core
  import mrpe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire rec_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output rec_out_t      out_data_o
);

  seq_ctrl_t ctrl;
  dp_stat_t  stat;
  logic      busy;
  logic      out_free;
  logic      emit;
  rec_out_t  word;
  logic      out_valid_q;
  rec_out_t  out_q;

  assign out_free = !out_valid_q || !out_stall_i;

  mrpe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  mrpe_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .emit_o    (emit),
    .word_o    (word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= word;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
